// ----- rtl/core/gbpe_pkg.sv -----
package gbpe_pkg;

  // Field widths of the request and result channels.
  localparam int GLYPH_W    = 8;
  localparam int COORD_W    = 12;
  localparam int ORIGIN_W   = 11;
  localparam int ROWB_W     = 4;
  localparam int COLOR_W    = 16;
  localparam int BITPOS_W   = 3;

  // Widest configuration register and index width of the write port.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  // Width used to compare row widths; holds MAX_ROW_BYTES up to 16.
  localparam int ROWB_CMP_W = 5;

  // Result tdata: pixel_x, pixel_y, pixel_color, 40 bits, five whole bytes.
  localparam int OUT_DATA_W = 2 * COORD_W + COLOR_W;

  // Parameter defaults.
  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_MAX_ROW_BYTES = 8;

  // Reset value of the row width register; the other configuration registers reset to zero.
  localparam logic [ROWB_W-1:0] ROW_BYTES_RST = ROWB_W'(2);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORIGIN_X  = 2'd0,
    REG_ORIGIN_Y  = 2'd1,
    REG_ROW_BYTES = 2'd2,
    REG_INK_COLOR = 2'd3
  } cfg_reg_t;

endpackage

// ----- rtl/core/glyph_bitmap_pixel_expander.sv -----
// Pipeline: a taken byte enters the expansion register, then each pixel write goes
// through the result register. One pixel write per cycle while out_tready allows; a byte
// keeps the expansion register until all its set bits are out, a zero byte gives none.
// Reset: rst_n is synchronous and active low; it clears the counters, the pending bit mask,
// the result valid flag and loads the configuration registers with their reset values.
module glyph_bitmap_pixel_expander #(
  parameter int MAX_ROWS      = gbpe_pkg::DEF_MAX_ROWS,
  parameter int MAX_ROW_BYTES = gbpe_pkg::DEF_MAX_ROW_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,

  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [gbpe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [gbpe_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  // Glyph byte requests.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gbpe_pkg::GLYPH_W-1:0]      in_tdata,   // [7:0] glyph_byte
  input  logic                              in_tlast,   // last_byte

  // Pixel write results.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gbpe_pkg::OUT_DATA_W-1:0]   out_tdata,  // [11:0] pixel_x, [23:12] pixel_y,
                                                        // [39:24] pixel_color
  output logic                              out_tlast   // last_pixel
);
  import gbpe_pkg::*;

  localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int ROW_W = $clog2(MAX_ROWS);

  // Configuration registers. They are only to be written while the block is idle; the block
  // itself does not enforce this, so the datapath reads them directly.
  logic [ORIGIN_W-1:0]   origin_x_r;
  logic [ORIGIN_W-1:0]   origin_y_r;
  logic [ROWB_W-1:0]     row_bytes_r;
  logic [COLOR_W-1:0]    ink_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      row_bytes_r <= ROW_BYTES_RST;
      ink_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ORIGIN_X:  origin_x_r  <= cfg_wdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y:  origin_y_r  <= cfg_wdata[ORIGIN_W-1:0];
        REG_ROW_BYTES: row_bytes_r <= cfg_wdata[ROWB_W-1:0];
        REG_INK_COLOR: ink_color_r <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counters, advanced once per accepted request.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Expansion register: the bits still to be emitted for the current byte,
  // plus the x base and y of that byte. The byte is busy while any bit remains.
  logic [GLYPH_W-1:0]  mask_r, mask_nxt;
  logic [COORD_W-1:0]  base_x_r, base_x_nxt;
  logic [COORD_W-1:0]  pos_y_r, pos_y_nxt;

  // Result register.
  logic                out_tvalid_r;
  logic [COORD_W-1:0]  out_x_r, out_x_nxt;
  logic [COORD_W-1:0]  out_y_r;
  logic                out_last_r, out_last_nxt;

  logic                busy;
  logic                out_free;
  logic                emit;
  logic                in_acc;
  logic [BITPOS_W-1:0] lead_pos;
  logic [GLYPH_W-1:0]  mask_left;
  logic [ROWB_CMP_W-1:0] eff_rowb;
  logic [ROWB_CMP_W-1:0] col_inc;

  assign busy     = |mask_r;
  assign out_free = !out_tvalid_r || out_tready;
  assign emit     = busy && out_free;

  // Leading set bit, counted from the left edge of the byte (bit 7 is position 0).
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < GLYPH_W; i++) begin
      if (mask_r[i]) begin
        lead_pos = BITPOS_W'(GLYPH_W - 1 - i);
      end
    end
  end

  assign mask_left = mask_r & ~(8'h80 >> lead_pos);

  // A new byte is taken when nothing is pending, or when the last pending
  // pixel moves into the result register in this very cycle.
  assign in_tready = !busy || (emit && (mask_left == '0));
  assign in_acc    = in_tvalid && in_tready;

  // Effective row width: zero reads as one, and it saturates at MAX_ROW_BYTES.
  always_comb begin
    eff_rowb = ROWB_CMP_W'(row_bytes_r);
    if (row_bytes_r == '0) begin
      eff_rowb = ROWB_CMP_W'(1);
    end else if (ROWB_CMP_W'(row_bytes_r) > ROWB_CMP_W'(MAX_ROW_BYTES)) begin
      eff_rowb = ROWB_CMP_W'(MAX_ROW_BYTES);
    end
  end

  assign col_inc = ROWB_CMP_W'(col_r) + ROWB_CMP_W'(1);

  // Counter update. A column at or past the row width (possible after a
  // width change) wraps to the next row, and the row saturates on the last one.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (in_tlast) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= eff_rowb) begin
        col_nxt = '0;
        if (row_r != ROW_W'(MAX_ROWS - 1)) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Expansion register update: a new byte overrides the one just finished.
  always_comb begin
    mask_nxt   = mask_r;
    base_x_nxt = base_x_r;
    pos_y_nxt  = pos_y_r;
    if (emit) begin
      mask_nxt = mask_left;
    end
    if (in_acc) begin
      mask_nxt   = in_tdata;
      base_x_nxt = COORD_W'({col_r, 3'b000}) + COORD_W'(origin_x_r);
      pos_y_nxt  = COORD_W'(row_r) + COORD_W'(origin_y_r);
    end
  end

  assign out_x_nxt    = base_x_r + COORD_W'(lead_pos);
  assign out_last_nxt = (mask_left == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      mask_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      mask_r <= mask_nxt;
      if (out_free) begin
        out_tvalid_r <= busy;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    base_x_r <= base_x_nxt;
    pos_y_r  <= pos_y_nxt;
    if (emit) begin
      out_x_r    <= out_x_nxt;
      out_y_r    <= pos_y_r;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {ink_color_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  // A nonzero byte always leaves pixels pending in the next cycle.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tdata != '0)) |=> busy)
    else $error("nonzero glyph byte taken without pending pixels");

  // Each emitted pixel retires exactly one pending bit.
  a_retire_one: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !in_acc) |=> ($countones(mask_r) == $countones($past(mask_r)) - 1))
    else $error("pixel emission did not retire exactly one bit");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

// ----- verif/testbench.sv -----
// Checks the glyph bitmap pixel expander against an in-bench predictor. The
// predictor keeps its own copy of the column and row counters and of the four
// configuration registers. Every glyph byte that the block accepts is expanded
// into the pixel writes it should cause, and every pixel write the block returns
// is checked against the oldest one still waiting.
module testbench;
  import gbpe_pkg::*;

  // Cycle budget. The slowest correct run sends at most 128 bytes. Each byte makes
  // up to eight writes, each write may sit out a long receiver stall, and each byte
  // may follow a sender gap. The limit is set far above the run time this allows.
  localparam int CYCLE_LIMIT = 300000;

  // One glyph byte request as the sender queues it.
  typedef struct packed {
    logic [GLYPH_W-1:0] bits;
    logic               last;
  } glyph_req_t;

  // One pixel write as the block should return it.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_wr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [GLYPH_W-1:0]    in_tdata = '0;
  logic                  in_tlast = 1'b0;

  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  glyph_bitmap_pixel_expander dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the configuration registers, loaded with their reset values.
  logic [ORIGIN_W-1:0] org_x = '0;
  logic [ORIGIN_W-1:0] org_y = '0;
  logic [ROWB_W-1:0]   row_width = ROW_BYTES_RST;
  logic [COLOR_W-1:0]  ink = '0;

  // Mirror of the glyph position counters.
  logic [2:0] col_idx = '0;
  logic [5:0] row_idx = '0;

  glyph_req_t glyph_q[$];   // requests still to be sent
  pixel_wr_t  pixel_q[$];   // pixel writes the block still owes

  glyph_req_t cur_req;
  int burst_left = 1;
  int gap_left = 0;
  int bytes_taken = 0;
  int pixels_checked = 0;
  int errors = 0;
  int cycle_cnt = 0;

  // Expands one accepted glyph byte into the expected pixel writes and then
  // moves the column and row counters on, exactly as the block must.
  function automatic void expand_glyph_byte(glyph_req_t req);
    pixel_wr_t wr;
    int width;
    for (int b = GLYPH_W - 1; b >= 0; b--) begin
      if (req.bits[b]) begin
        wr.x     = COORD_W'(8 * int'(col_idx) + int'(org_x) + (GLYPH_W - 1 - b));
        wr.y     = COORD_W'(int'(row_idx) + int'(org_y));
        wr.color = ink;
        // The write is the byte's final one when no set bit lies to its right.
        wr.last  = ((req.bits & ~(8'hFF << b)) == 8'h00);
        pixel_q.push_back(wr);
      end
    end
    // A zero width behaves as one byte, an oversized one as the widest row.
    width = int'(row_width);
    if (width == 0) begin
      width = 1;
    end
    if (width > DEF_MAX_ROW_BYTES) begin
      width = DEF_MAX_ROW_BYTES;
    end
    if (req.last) begin
      col_idx = '0;
      row_idx = '0;
    end else if (int'(col_idx) + 1 >= width) begin
      // End of a row: the column wraps, and the row stops at the bottom one.
      col_idx = '0;
      if (int'(row_idx) < DEF_MAX_ROWS - 1) begin
        row_idx = row_idx + 6'd1;
      end
    end else begin
      col_idx = col_idx + 3'd1;
    end
  endfunction

  // Sender. It works in bursts of random length separated by random gaps. A
  // request is predicted at the edge where the block takes it, and the next one
  // goes out at that same edge. The valid gets a single assignment per edge.
  always @(posedge clk) begin : feed_proc
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expand_glyph_byte(cur_req);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (glyph_q.size() > 0) begin
          cur_req = glyph_q.pop_front();
          in_tdata <= cur_req.bits;
          in_tlast <= cur_req.last;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Now and then a long burst with no gap, so back-to-back requests
            // meet the block while it is still busy expanding a byte.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
        in_tvalid <= next_valid;
      end
    end
  end

  // Receiver. Its ready follows a rotating 16-bit pattern that is replaced
  // whenever pat_age wraps. Some patterns never stall, some stall for long stretches.
  // Every pattern has bit 0 set, so the receiver is never stuck.
  logic [15:0] ready_pat = 16'hFFFF;
  int pat_age = 0;

  always @(posedge clk) begin : sink_proc
    pixel_wr_t got;
    pixel_wr_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.x     = out_tdata[COORD_W-1:0];
        got.y     = out_tdata[2*COORD_W-1:COORD_W];
        got.color = out_tdata[OUT_DATA_W-1:2*COORD_W];
        got.last  = out_tlast;
        if (pixel_q.size() == 0) begin
          $display("%0t unexpected pixel write: x %0d y %0d color %h last %b",
                   $time, got.x, got.y, got.color, got.last);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          pixels_checked++;
          if (got.x !== want.x) begin
            $display("%0t pixel_x mismatch: expected %0d, actual %0d", $time, want.x, got.x);
            errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t pixel_y mismatch: expected %0d, actual %0d", $time, want.y, got.y);
            errors++;
          end
          if (got.color !== want.color) begin
            $display("%0t pixel_color mismatch: expected %h, actual %h",
                     $time, want.color, got.color);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t last_pixel mismatch: expected %b, actual %b",
                     $time, want.last, got.last);
            errors++;
          end
        end
      end
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      pat_age++;
      if (pat_age == 48) begin
        pat_age = 0;
        case ($urandom_range(0, 3))
          0: ready_pat = 16'hFFFF;
          1: ready_pat = 16'($urandom) | 16'h0001;
          2: ready_pat = 16'h0001;
          default: ready_pat = 16'h00FF;
        endcase
      end
      out_tready <= ready_pat[0];
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d requests queued and %0d pixel writes owed",
               $time, glyph_q.size(), pixel_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Register writes happen only while the block is idle. The predictor's copy
  // is updated here, together with the write, and each field keeps only its own
  // width of the write data.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X:  org_x = val[ORIGIN_W-1:0];
      REG_ORIGIN_Y:  org_y = val[ORIGIN_W-1:0];
      REG_ROW_BYTES: row_width = val[ROWB_W-1:0];
      REG_INK_COLOR: ink = val[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every request has been taken and every owed write has been
  // returned. The extra cycles after that let a trailing zero byte, which
  // returns nothing, finish its single pass through the block.
  task automatic wait_idle();
    do @(negedge clk);
    while (glyph_q.size() != 0 || in_tvalid || pixel_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_byte(logic [GLYPH_W-1:0] bits, logic last);
    glyph_q.push_back('{bits: bits, last: last});
  endtask

  // A glyph of random content. Most bytes are random. Empty and fully inked
  // bytes are mixed in on purpose. Without the end marker the glyph simply runs
  // on into the next phase.
  task automatic push_glyph(int len, logic terminated);
    logic [GLYPH_W-1:0] bits;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: bits = 8'h00;
        1: bits = 8'hFF;
        default: bits = GLYPH_W'($urandom);
      endcase
      push_byte(bits, terminated && (i == len - 1));
    end
  endtask

  initial begin : stim_proc
    logic [ROWB_W-1:0] width_pick;
    int sent;
    int len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: default row width of two bytes, origin zero, black
    // ink. Single leftmost and rightmost pixels, a full byte, an empty byte and
    // a glyph end marker.
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b1);
    wait_idle();

    // Both origins at their maximum and white ink. The row width write carries
    // junk in its upper bits, which leaves a zero width that behaves as one byte.
    write_reg(REG_ORIGIN_X, 16'h07FF);
    write_reg(REG_ORIGIN_Y, 16'hFFFF);
    write_reg(REG_ROW_BYTES, 16'hFFF0);
    write_reg(REG_INK_COLOR, 16'hFFFF);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // The widest row code (15) clamps to eight bytes. Nine bytes run the column
    // through all eight positions and wrap it. The origin x write also carries
    // junk above the register width.
    write_reg(REG_ORIGIN_X, 16'hF800);
    write_reg(REG_ORIGIN_Y, 16'h0000);
    write_reg(REG_ROW_BYTES, 16'h000F);
    write_reg(REG_INK_COLOR, 16'h0000);
    for (int b = GLYPH_W - 1; b >= 0; b--) begin
      push_byte(GLYPH_W'(1) << b, 1'b0);
    end
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // Row width changed in the middle of a glyph. Three bytes leave the column
    // at 3 in a four-byte row. After the width drops to two, the next byte
    // still draws at column 3, and the byte after it wraps to a new row.
    write_reg(REG_ROW_BYTES, 16'd4);
    write_reg(REG_INK_COLOR, 16'hF81F);
    push_byte(8'h18, 1'b0);
    push_byte(8'h18, 1'b0);
    push_byte(8'h18, 1'b0);
    wait_idle();
    write_reg(REG_ROW_BYTES, 16'd2);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h3C, 1'b1);
    wait_idle();

    // Random phases. Each phase starts with new settings. Phase 0 sends one
    // long one-byte-wide glyph, which runs the row counter into its bottom row
    // and holds it there. The others send short glyphs at widths of 8, the zero
    // code, 15, 3 and a random one. Some of those glyphs are left open across
    // the next register change.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: width_pick = 4'd1;
        1: width_pick = 4'd8;
        2: width_pick = 4'd0;
        3: width_pick = 4'd15;
        4: width_pick = 4'd3;
        default: width_pick = ROWB_W'($urandom);
      endcase
      case (ph)
        1: begin
          write_reg(REG_ORIGIN_X, 16'h07FF);
          write_reg(REG_ORIGIN_Y, 16'h07FF);
        end
        2: begin
          write_reg(REG_ORIGIN_X, 16'h0000);
          write_reg(REG_ORIGIN_Y, 16'h0000);
        end
        default: begin
          write_reg(REG_ORIGIN_X, CFG_DATA_W'($urandom));
          write_reg(REG_ORIGIN_Y, CFG_DATA_W'($urandom));
        end
      endcase
      write_reg(REG_ROW_BYTES, {12'h000, width_pick});
      write_reg(REG_INK_COLOR, CFG_DATA_W'($urandom));
      if (ph == 0) begin
        push_glyph(66, 1'b1);
      end else begin
        sent = 0;
        while (sent < 4) begin
          len = $urandom_range(1, 5);
          push_glyph(len, $urandom_range(0, 4) != 0);
          sent += len;
        end
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    $display("Sent %0d glyph bytes and checked %0d pixel writes; %0d mismatches.",
             bytes_taken, pixels_checked, errors);
    $display("Zero, narrow, full and oversized row widths, both origin extremes and the"
             , " bottom-row clamp were run.");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pixel_q.size() != 0) begin
        $display("%0t %0d expected pixel writes never arrived", $time, pixel_q.size());
      end
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gbpe_pkg.sv
rtl/core/glyph_bitmap_pixel_expander.sv
verif/testbench.sv
